FILE: hw/rtl/rbiu_pkg.sv
// Shared constants and command/status types for the bitplane image unpacker.
`timescale 1ns / 1ps
`default_nettype none
package rbiu_pkg;

  localparam int DEF_PLANE_LINE_BYTES = 40;
  localparam int DEF_NUM_PLANES       = 4;
  localparam int DEF_NUM_LINES        = 200;
  localparam int DEF_LINE_STRIDE      = 160;

  localparam int          ADDR_W          = 15;
  localparam logic [5:0]  HDR_REST        = 6'd33;
  localparam logic [7:0]  MODE_COMPRESSED = 8'h80;
  localparam logic [14:0] ADDR_LAST       = 15'h7FFF;
  localparam logic [8:0]  REPEAT_BASE     = 9'd257;

  typedef struct packed {
    logic accept;
    logic emit;
  } rbiu_cmd_t;

  typedef struct packed {
    logic single_wr;
    logic run_start;
    logic run_end;
  } rbiu_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rbiu_ctrl.sv
// Controller state machine: input transfers, repeat-run sequencing, output valid.
`timescale 1ns / 1ps
`default_nettype none
module rbiu_ctrl
  import rbiu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire rbiu_status_t st,
  output rbiu_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign cmd.accept = in_valid && !in_stall;
  assign cmd.emit   = (state_r == S_RUN) && out_free;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && st.single_wr) out_valid_nxt = 1'b1;
        if (cmd.accept && st.run_start) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (cmd.emit) begin
          out_valid_nxt = 1'b1;
          if (st.run_end) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rbiu_dp.sv
// Datapath: header and PackBits decode, bitplane address walk, output register.
`timescale 1ns / 1ps
`default_nettype none
module rbiu_dp
  import rbiu_pkg::*;
#(
  parameter int PLANE_LINE_BYTES = DEF_PLANE_LINE_BYTES,
  parameter int NUM_PLANES       = DEF_NUM_PLANES,
  parameter int NUM_LINES        = DEF_NUM_LINES,
  parameter int LINE_STRIDE      = DEF_LINE_STRIDE
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_file_start,
  input  wire rbiu_cmd_t   cmd,
  output rbiu_status_t     st,
  output logic [14:0]      out_wr_addr,
  output logic [7:0]       out_wr_data,
  output logic             out_run_last,
  output logic             out_image_done,
  output logic             out_overrun_error
);

  localparam int POS_W   = $clog2(PLANE_LINE_BYTES);
  localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int LINE_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int SUM_W   = 20;

  logic [5:0]         header_r, header_nxt;
  logic               comp_r, comp_nxt;
  logic [7:0]         lit_r, lit_nxt;
  logic [7:0]         rep_r, rep_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [14:0]        raw_r, raw_nxt;
  logic               fin_r, fin_nxt;
  logic [7:0]         run_cnt_r, run_cnt_nxt;
  logic [7:0]         run_data_r, run_data_nxt;
  logic               run_ovr_r, run_ovr_nxt;

  logic               out_load;
  logic [14:0]        addr_nxt;
  logic [7:0]         data_nxt;
  logic               last_nxt, done_nxt, ovr_nxt;

  logic               pos_wrap, plane_wrap, line_wrap, adv_done, do_adv;
  logic [SUM_W-1:0]   addr_sum;
  logic [14:0]        plane_addr;
  logic [7:0]         room;
  logic               live;

  assign pos_wrap   = ({1'b0, pos_r} + 1'b1) >= (POS_W+1)'(PLANE_LINE_BYTES);
  assign plane_wrap = ({1'b0, plane_r} + 1'b1) >= (PLANE_W+1)'(NUM_PLANES);
  assign line_wrap  = ({1'b0, line_r} + 1'b1) >= (LINE_W+1)'(NUM_LINES);
  assign adv_done   = pos_wrap && plane_wrap && line_wrap;

  assign addr_sum   = SUM_W'(line_r) * SUM_W'(LINE_STRIDE)
                    + (SUM_W'(plane_r) << 1)
                    + ((SUM_W'(pos_r) >> 1) << 3)
                    + SUM_W'(pos_r[0]);
  assign plane_addr = addr_sum[14:0];
  assign room       = 8'(PLANE_LINE_BYTES) - 8'(pos_r);

  assign live         = !in_file_start && !fin_r && (header_r == 6'd0);
  assign st.single_wr = live && (!comp_r || (lit_r != 8'd0));
  assign st.run_start = live && comp_r && (lit_r == 8'd0) && (rep_r != 8'd0);
  assign st.run_end   = (run_cnt_r == 8'd1) || adv_done;

  always_comb begin
    header_nxt   = header_r;
    comp_nxt     = comp_r;
    lit_nxt      = lit_r;
    rep_nxt      = rep_r;
    pos_nxt      = pos_r;
    plane_nxt    = plane_r;
    line_nxt     = line_r;
    raw_nxt      = raw_r;
    fin_nxt      = fin_r;
    run_cnt_nxt  = run_cnt_r;
    run_data_nxt = run_data_r;
    run_ovr_nxt  = run_ovr_r;
    out_load     = 1'b0;
    addr_nxt     = plane_addr;
    data_nxt     = in_byte;
    last_nxt     = 1'b1;
    done_nxt     = adv_done;
    ovr_nxt      = 1'b0;
    do_adv       = 1'b0;

    if (cmd.emit) begin
      out_load    = 1'b1;
      data_nxt    = run_data_r;
      last_nxt    = st.run_end;
      ovr_nxt     = run_ovr_r;
      run_cnt_nxt = run_cnt_r - 8'd1;
      do_adv      = 1'b1;
    end else if (cmd.accept) begin
      priority if (in_file_start) begin
        comp_nxt   = (in_byte == MODE_COMPRESSED);
        header_nxt = HDR_REST;
        lit_nxt    = 8'd0;
        rep_nxt    = 8'd0;
        pos_nxt    = '0;
        plane_nxt  = '0;
        line_nxt   = '0;
        raw_nxt    = 15'd0;
        fin_nxt    = 1'b0;
      end else if (fin_r) begin
        fin_nxt = 1'b1;
      end else if (header_r != 6'd0) begin
        header_nxt = header_r - 6'd1;
      end else if (!comp_r) begin
        out_load = 1'b1;
        addr_nxt = raw_r;
        done_nxt = (raw_r == ADDR_LAST);
        raw_nxt  = raw_r + 15'd1;
        if (raw_r == ADDR_LAST) fin_nxt = 1'b1;
      end else if (lit_r != 8'd0) begin
        out_load = 1'b1;
        do_adv   = 1'b1;
        lit_nxt  = adv_done ? 8'd0 : lit_r - 8'd1;
      end else if (rep_r != 8'd0) begin
        rep_nxt      = 8'd0;
        run_data_nxt = in_byte;
        run_ovr_nxt  = rep_r > room;
        run_cnt_nxt  = (rep_r > room) ? room : rep_r;
      end else if (in_byte[7]) begin
        rep_nxt = 8'(REPEAT_BASE - {1'b0, in_byte});
      end else begin
        lit_nxt = in_byte + 8'd1;
      end
    end

    if (do_adv) begin
      if (pos_wrap) begin
        pos_nxt = '0;
        if (plane_wrap) begin
          plane_nxt = '0;
          if (line_wrap) fin_nxt = 1'b1;
          else line_nxt = line_r + 1'b1;
        end else begin
          plane_nxt = plane_r + 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= 6'd0;
      comp_r    <= 1'b0;
      lit_r     <= 8'd0;
      rep_r     <= 8'd0;
      pos_r     <= '0;
      plane_r   <= '0;
      line_r    <= '0;
      raw_r     <= 15'd0;
      fin_r     <= 1'b1;
      run_cnt_r <= 8'd0;
    end else begin
      header_r  <= header_nxt;
      comp_r    <= comp_nxt;
      lit_r     <= lit_nxt;
      rep_r     <= rep_nxt;
      pos_r     <= pos_nxt;
      plane_r   <= plane_nxt;
      line_r    <= line_nxt;
      raw_r     <= raw_nxt;
      fin_r     <= fin_nxt;
      run_cnt_r <= run_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_data_r <= run_data_nxt;
    run_ovr_r  <= run_ovr_nxt;
    if (out_load) begin
      out_wr_addr       <= addr_nxt;
      out_wr_data       <= data_nxt;
      out_run_last      <= last_nxt;
      out_image_done    <= done_nxt;
      out_overrun_error <= ovr_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rle_bitplane_image_unpacker_top.sv
// Top level of the run-length bitplane image unpacker.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_byte, in_file_start
//   out_    | output    | out_valid/out_stall  | out_wr_addr, out_wr_data, out_run_last,
//           |           |                      | out_image_done, out_overrun_error
//
// Header and control bytes are consumed without a write; a raw or literal byte
// loads the output register directly.
// A repeat data byte is taken, then written n times from the run counter, one a cycle
// unless the output stalls, n being the run length clipped to the end of the plane line.
// Synchronous active-low reset; the block then ignores bytes until a file start.
// A stalled output holds the output register and the run counter, and stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module rle_bitplane_image_unpacker_top
  import rbiu_pkg::*;
#(
  parameter int PLANE_LINE_BYTES = DEF_PLANE_LINE_BYTES,
  parameter int NUM_PLANES       = DEF_NUM_PLANES,
  parameter int NUM_LINES        = DEF_NUM_LINES,
  parameter int LINE_STRIDE      = DEF_LINE_STRIDE
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_file_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [14:0]      out_wr_addr,
  output logic [7:0]       out_wr_data,
  output logic             out_run_last,
  output logic             out_image_done,
  output logic             out_overrun_error
);

  rbiu_cmd_t    cmd;
  rbiu_status_t st;

  rbiu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  rbiu_dp #(
    .PLANE_LINE_BYTES (PLANE_LINE_BYTES),
    .NUM_PLANES       (NUM_PLANES),
    .NUM_LINES        (NUM_LINES),
    .LINE_STRIDE      (LINE_STRIDE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte           (in_byte),
    .in_file_start     (in_file_start),
    .cmd               (cmd),
    .st                (st),
    .out_wr_addr       (out_wr_addr),
    .out_wr_data       (out_wr_data),
    .out_run_last      (out_run_last),
    .out_image_done    (out_image_done),
    .out_overrun_error (out_overrun_error)
  );

  a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.emit))
    else $error("input transfer during repeat run");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && st.run_start) |=> in_stall)
    else $error("input not held after repeat run start");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_done) |-> out_run_last)
    else $error("image end write not marked last");

endmodule
`default_nettype wire
